@@ hdl/ope_pkg.sv @@
// ----------------------------------------------------------------------------
// ope_pkg
// Shared widths, codes, types and saturation helper for the orthogonal
// polynomial evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package ope_pkg;

    localparam int DATA_W          = 32;
    localparam int IDX_W           = 5;
    localparam int DEG_W           = 5;
    localparam int SUM_W           = 66;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_DEGREE = 2'd0;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic  ovf;
        data_t val;
    } sat_t;

    // datapath strobes issued by the sequencer
    typedef struct packed {
        logic init;
        logic prep;
        logic mul;
        logic acc;
    } dp_ctl_t;

    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if (v > SAT_HI)
        begin
            r.ovf = 1'b1;
            r.val = SAT_HI[DATA_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r.ovf = 1'b1;
            r.val = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ope_if.sv @@
// ----------------------------------------------------------------------------
// ope_in_if / ope_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ope_in_if import ope_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [IDX_W-1:0]   index;
    data_t              coef_a;
    data_t              coef_alpha;
    data_t              coef_beta;
    data_t              point_x;

    modport source (output valid, op, index, coef_a, coef_alpha, coef_beta, point_x,
                    input ready);
    modport sink   (input valid, op, index, coef_a, coef_alpha, coef_beta, point_x,
                    output ready);
endinterface

interface ope_out_if import ope_pkg::*; ();
    logic   valid;
    logic   ready;
    data_t  value;
    data_t  first_deriv;
    data_t  second_deriv;
    logic   overflow;

    modport source (output valid, value, first_deriv, second_deriv, overflow,
                    input ready);
    modport sink   (input valid, value, first_deriv, second_deriv, overflow,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/orthogonal_poly_eval_with_derivs_core.sv @@
// ----------------------------------------------------------------------------
// orthogonal_poly_eval_with_derivs_core
// Orthogonal polynomial series evaluator with first and second derivative.
//
// din carries two kinds of beat. op = write stores (coef_a, coef_alpha,
// coef_beta) at index and returns nothing; an index at or above
// TABLE_DEPTH is dropped. op = eval runs Clenshaw's recurrence at
// point_x from the configured degree m (clipped to TABLE_DEPTH-1) down to
// zero and returns one beat on dout: value, first_deriv, second_deriv,
// saturated Q(32-FRAC_BITS).FRAC_BITS, and a sticky overflow flag.
// An eval runs one coefficient memory read, one difference stage (skipped
// at degree zero), a multiply state (six parallel 32x32 products) and a
// sum state per recurrence step, and a dout load. One eval is in flight
// at a time; din is ready again in the cycle in which the result appears
// on dout. dout is registered, so a stalled receiver holds the result
// while the next eval runs; a finished eval then waits until dout frees.
// The user writes degree over APB at address 0 only while idle; the block
// does not enforce this. pready is tied high. Reset clears the sequencer,
// the degree register and dout valid; the coefficient memories are not
// cleared and must be written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module orthogonal_poly_eval_with_derivs_core import ope_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    ope_in_if.sink                 din,
    ope_out_if.source              dout,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_MUL,
        S_ACC,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic [DEG_W-1:0] degree_reg;
    logic [AW-1:0]    m_reg, j_reg;
    data_t            x_reg;
    logic             out_valid_reg;
    data_t            out_value_reg, out_d1_reg, out_d2_reg;
    logic             out_ovf_reg;

    logic          in_take, wr_en, rd_en, out_free;
    logic [AW-1:0] m_sat, rd_addr_a, rd_addr_b;
    dp_ctl_t       ctl;
    data_t         rd_a, rd_alpha, rd_beta;
    data_t         dp_b, dp_db, dp_d2b;
    logic          dp_ovf;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DEGREE) ? APB_DW'(degree_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_DEGREE)
        begin
            degree_reg <= pwdata[DEG_W-1:0];
        end
    end

    assign m_sat = (int'(degree_reg) > TABLE_DEPTH - 1) ? AW'(TABLE_DEPTH - 1)
                                                        : AW'(degree_reg);

    assign din.ready = (state_reg == S_IDLE);
    assign in_take   = din.valid && din.ready;
    assign wr_en     = in_take && din.op == OP_WRITE && int'(din.index) < TABLE_DEPTH;
    assign out_free  = !out_valid_reg || dout.ready;

    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr_a = m_sat;
        rd_addr_b = m_reg;
        case (state_reg)
            S_IDLE:
            begin
                rd_en     = in_take && din.op == OP_EVAL;
                rd_addr_a = m_sat;
            end
            S_LOAD:
            begin
                rd_en     = (m_reg != '0);
                rd_addr_a = m_reg - AW'(1);
                rd_addr_b = m_reg;
            end
            S_MUL:
            begin
                rd_en     = (j_reg != '0);
                rd_addr_a = j_reg - AW'(1);
                rd_addr_b = j_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ctl.init = (state_reg == S_LOAD);
        ctl.prep = (state_reg == S_PREP) || (state_reg == S_ACC && j_reg != '0);
        ctl.mul  = (state_reg == S_MUL);
        ctl.acc  = (state_reg == S_ACC);
    end

    ope_coef_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (AW'(din.index)),
        .wr_a      (din.coef_a),
        .wr_alpha  (din.coef_alpha),
        .wr_beta   (din.coef_beta),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_a      (rd_a),
        .rd_alpha  (rd_alpha),
        .rd_beta   (rd_beta)
    );

    ope_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .ctl      (ctl),
        .x        (x_reg),
        .rd_a     (rd_a),
        .rd_alpha (rd_alpha),
        .rd_beta  (rd_beta),
        .b        (dp_b),
        .db       (dp_db),
        .d2b      (dp_d2b),
        .ovf      (dp_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            m_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            if (dout.valid && dout.ready && !(state_reg == S_OUT && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_take && din.op == OP_EVAL)
                    begin
                        x_reg     <= din.point_x;
                        m_reg     <= m_sat;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    j_reg     <= m_reg - AW'(1);
                    state_reg <= (m_reg == '0) ? S_OUT : S_PREP;
                end
                S_PREP:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (j_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        j_reg     <= j_reg - AW'(1);
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= dp_b;
                        out_d1_reg    <= dp_db;
                        out_d2_reg    <= dp_d2b;
                        out_ovf_reg   <= dp_ovf;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign dout.valid        = out_valid_reg;
    assign dout.value        = out_value_reg;
    assign dout.first_deriv  = out_d1_reg;
    assign dout.second_deriv = out_d2_reg;
    assign dout.overflow     = out_ovf_reg;

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("coefficient write and read in the same cycle");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_ACC) |-> j_reg < m_reg)
        else $error("step index outside the configured degree");

    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && j_reg != '0)
        |=> (state_reg == S_MUL && j_reg == $past(j_reg) - AW'(1)))
        else $error("recurrence step did not advance by one");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free)
        |=> (dout.valid && dout.value == $past(dp_b) && dout.overflow == $past(dp_ovf)))
        else $error("result beat not loaded from the datapath");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && din.op == OP_EVAL) |=> (!din.ready ##1 !din.ready))
        else $error("new request taken while an evaluation is running");

endmodule

`default_nettype wire

@@ hdl/ope_coef_mem.sv @@
// ----------------------------------------------------------------------------
// ope_coef_mem
// Coefficient store: {a, alpha} and beta in two single-write memories,
// each with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ope_coef_mem import ope_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire data_t         wr_a,
    input  wire data_t         wr_alpha,
    input  wire data_t         wr_beta,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output data_t              rd_a,
    output data_t              rd_alpha,
    output data_t              rd_beta
);

    logic [2*DATA_W-1:0] mem_aal [DEPTH];
    logic [DATA_W-1:0]   mem_bet [DEPTH];
    logic [2*DATA_W-1:0] rd_aal_reg;
    logic [DATA_W-1:0]   rd_bet_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_aal[wr_addr] <= {wr_a, wr_alpha};
        end
        if (rd_en)
        begin
            rd_aal_reg <= mem_aal[rd_addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_bet[wr_addr] <= wr_beta;
        end
        if (rd_en)
        begin
            rd_bet_reg <= mem_bet[rd_addr_b];
        end
    end

    assign rd_a     = rd_aal_reg[2*DATA_W-1:DATA_W];
    assign rd_alpha = rd_aal_reg[DATA_W-1:0];
    assign rd_beta  = rd_bet_reg;

endmodule

`default_nettype wire

@@ hdl/ope_dp.sv @@
// ----------------------------------------------------------------------------
// ope_dp
// Clenshaw recurrence datapath: six product registers, one sum stage,
// recurrence state for value and both derivatives, sticky overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module ope_dp import ope_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic    clk,
    input  wire dp_ctl_t ctl,
    input  wire data_t   x,
    input  wire data_t   rd_a,
    input  wire data_t   rd_alpha,
    input  wire data_t   rd_beta,
    output data_t        b,
    output data_t        db,
    output data_t        d2b,
    output logic         ovf
);

    data_t t_reg, bb_reg, aj_reg;
    data_t b_reg, b1_reg, db_reg, db1_reg, d2b_reg, d2b1_reg;
    logic  ovf_reg;

    logic signed [63:0] p_tb_reg, p_tdb_reg, p_td2_reg;
    logic signed [63:0] p_bb_reg, p_bdb_reg, p_bd2_reg;

    logic signed [63:0] m_tb, m_tdb, m_td2, m_bb, m_bdb, m_bd2;
    logic signed [SUM_W-1:0] s_t, s_b, s_d, s_d2;
    sat_t  r_t, r_b, r_d, r_d2;
    logic  ovf_next;

    assign m_tb  = 64'(t_reg)  * 64'(b_reg);
    assign m_tdb = 64'(t_reg)  * 64'(db_reg);
    assign m_td2 = 64'(t_reg)  * 64'(d2b_reg);
    assign m_bb  = 64'(bb_reg) * 64'(b1_reg);
    assign m_bdb = 64'(bb_reg) * 64'(db1_reg);
    assign m_bd2 = 64'(bb_reg) * 64'(d2b1_reg);

    assign s_t  = SUM_W'(x) - SUM_W'(rd_alpha);
    assign s_b  = SUM_W'(aj_reg) + SUM_W'(p_tb_reg) - SUM_W'(p_bb_reg);
    assign s_d  = SUM_W'(b_reg) + SUM_W'(p_tdb_reg) - SUM_W'(p_bdb_reg);
    assign s_d2 = (SUM_W'(db_reg) <<< 1) + SUM_W'(p_td2_reg) - SUM_W'(p_bd2_reg);

    always_comb
    begin
        r_t  = sat32(s_t);
        r_b  = sat32(s_b);
        r_d  = sat32(s_d);
        r_d2 = sat32(s_d2);
        ovf_next = ovf_reg
                 | (ctl.prep & r_t.ovf)
                 | (ctl.acc & (r_b.ovf | r_d.ovf | r_d2.ovf));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            // start at degree m: b = a[m], other recurrence state and overflow zero
            b_reg    <= rd_a;
            b1_reg   <= '0;
            db_reg   <= '0;
            db1_reg  <= '0;
            d2b_reg  <= '0;
            d2b1_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.acc)
            begin
                b1_reg   <= b_reg;
                b_reg    <= r_b.val;
                db1_reg  <= db_reg;
                db_reg   <= r_d.val;
                d2b1_reg <= d2b_reg;
                d2b_reg  <= r_d2.val;
            end
            ovf_reg <= ovf_next;
        end

        if (ctl.prep)
        begin
            t_reg  <= r_t.val;
            bb_reg <= rd_beta;
            aj_reg <= rd_a;
        end

        if (ctl.mul)
        begin
            p_tb_reg  <= m_tb  >>> FRAC_BITS;
            p_tdb_reg <= m_tdb >>> FRAC_BITS;
            p_td2_reg <= m_td2 >>> FRAC_BITS;
            p_bb_reg  <= m_bb  >>> FRAC_BITS;
            p_bdb_reg <= m_bdb >>> FRAC_BITS;
            p_bd2_reg <= m_bd2 >>> FRAC_BITS;
        end
    end

    assign b   = b_reg;
    assign db  = db_reg;
    assign d2b = d2b_reg;
    assign ovf = ovf_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_orthogonal_poly_eval_with_derivs_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_orthogonal_poly_eval_with_derivs_core
// Self-checking bench for the Clenshaw series evaluator. Coefficient writes
// and evaluations go in on din. Every evaluation is predicted in the bench
// in 64-bit fixed point with saturation, and the prediction is compared
// with the dout beat. The degree is set over APB between phases and read
// back. Both channels idle at random but in the last phase. One phase holds
// dout off for a long stretch while evaluations keep arriving.
// ----------------------------------------------------------------------------
module tb_orthogonal_poly_eval_with_derivs_core import ope_pkg::*;;

    localparam int     DEPTH    = TABLE_DEPTH_DEF;
    localparam int     FRAC     = FRAC_BITS_DEF;
    localparam int     SETTLE   = 2 * (DEPTH - 1) + 8;
    localparam int     HOLD     = 400;
    localparam int     WD_LIMIT = 4 * (HOLD + 2 * DEPTH + 4 + 10 + SETTLE);
    localparam longint Q_MAX    = 64'sd2147483647;
    localparam longint Q_MIN    = -64'sd2147483648;
    localparam data_t  W_MAX    = 32'sh7FFF_FFFF;
    localparam data_t  W_MIN    = 32'sh8000_0000;
    localparam data_t  Q_ONE    = 32'sh0001_0000;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] index;
        data_t            a;
        data_t            alpha;
        data_t            beta;
        data_t            x;
    } req_t;

    typedef struct packed {
        data_t value;
        data_t d1;
        data_t d2;
        logic  ovf;
    } res_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ope_in_if  din_if ();
    ope_out_if dout_if ();

    orthogonal_poly_eval_with_derivs_core DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    data_t            tbl_a     [DEPTH];
    data_t            tbl_alpha [DEPTH];
    data_t            tbl_beta  [DEPTH];
    logic [DEG_W-1:0] deg_shadow;
    res_t             results_due[$];
    res_t             seen_res;
    res_t             due_res;
    string            diff_msg;

    bit tx_gaps;
    bit rx_gaps;
    bit hold_req;
    int n_err;
    int n_writes;
    int n_evals;
    int n_results;
    int n_sat;
    int n_degrees;
    int idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic longint clip32(input longint v, output bit hit);
        hit = 1'b1;
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        hit = 1'b0;
        return v;
    endfunction

    function automatic longint qmul(input longint p, input longint q);
        return (p * q) >>> FRAC;
    endfunction

    function automatic res_t clenshaw_eval(input data_t x);
        longint xv, b, b1, db, db1, d2b, d2b1, t, bb, nb, nd, nd2;
        bit     ovf, hit;
        int     m;
        res_t   r;
        xv  = longint'(x);
        ovf = 1'b0;
        m   = int'(deg_shadow);
        if (m > DEPTH - 1)
            m = DEPTH - 1;
        if (m == 0)
        begin
            b   = longint'(tbl_a[0]);
            db  = 0;
            d2b = 0;
        end
        else
        begin
            t    = clip32(xv - longint'(tbl_alpha[m-1]), hit);
            ovf |= hit;
            b    = clip32(longint'(tbl_a[m-1]) + qmul(t, longint'(tbl_a[m])), hit);
            ovf |= hit;
            b1   = longint'(tbl_a[m]);
            db   = longint'(tbl_a[m]);
            db1  = 0;
            d2b  = 0;
            d2b1 = 0;
            for (int j = m - 2; j >= 0; j--)
            begin
                bb   = longint'(tbl_beta[j+1]);
                t    = clip32(xv - longint'(tbl_alpha[j]), hit);
                ovf |= hit;
                nd2  = clip32(2 * db + qmul(t, d2b) - qmul(bb, d2b1), hit);
                ovf |= hit;
                nd   = clip32(b + qmul(t, db) - qmul(bb, db1), hit);
                ovf |= hit;
                nb   = clip32(longint'(tbl_a[j]) + qmul(t, b) - qmul(bb, b1), hit);
                ovf |= hit;
                b1   = b;
                b    = nb;
                db1  = db;
                db   = nd;
                d2b1 = d2b;
                d2b  = nd2;
            end
        end
        r.value = b[31:0];
        r.d1    = db[31:0];
        r.d2    = d2b[31:0];
        r.ovf   = ovf;
        return r;
    endfunction

    task automatic take_item(input req_t r);
        if (r.op == OP_WRITE)
        begin
            n_writes++;
            if (r.index < DEPTH)
            begin
                tbl_a[r.index]     = r.a;
                tbl_alpha[r.index] = r.alpha;
                tbl_beta[r.index]  = r.beta;
            end
        end
        else
        begin
            n_evals++;
            results_due.push_back(clenshaw_eval(r.x));
        end
    endtask

    task automatic note_mismatch(input string msg);
        n_err++;
        if (n_err <= 10)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic req_t mk_req(input logic op, input int idx, input data_t a,
                                    input data_t alpha, input data_t beta, input data_t x);
        req_t r;
        r.op    = op;
        r.index = IDX_W'(idx);
        r.a     = a;
        r.alpha = alpha;
        r.beta  = beta;
        r.x     = x;
        return r;
    endfunction

    function automatic data_t wild_word();
        case ($urandom_range(0, 9))
            0: return W_MIN;
            1: return W_MAX;
            2: return '0;
            3: return -1;
            4: return Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic data_t tame_word(input int span);
        return data_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic req_t random_item(input int eval_pct);
        req_t r;
        r.op    = ($urandom_range(0, 99) < eval_pct) ? OP_EVAL : OP_WRITE;
        r.index = IDX_W'($urandom_range(0, DEPTH - 1));
        r.a     = ($urandom_range(0, 9) == 0) ? wild_word() : tame_word(1 << 16);
        r.alpha = ($urandom_range(0, 9) == 0) ? wild_word() : tame_word(1 << 15);
        r.beta  = ($urandom_range(0, 9) == 0) ? wild_word() : tame_word(1 << 14);
        r.x     = ($urandom_range(0, 4) == 0) ? wild_word() : tame_word(1 << 15);
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic push_item(input req_t r);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            din_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        din_if.valid      <= 1'b1;
        din_if.op         <= r.op;
        din_if.index      <= r.index;
        din_if.coef_a     <= r.a;
        din_if.coef_alpha <= r.alpha;
        din_if.coef_beta  <= r.beta;
        din_if.point_x    <= r.x;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        take_item(r);
        @(negedge clk);
    endtask

    task automatic settle();
        din_if.valid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        if (wr && addr == ADDR_DEGREE)
            deg_shadow = wdata[DEG_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_degree(input int d);
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b1, ADDR_DEGREE, APB_DW'(d), rd);
        apb_xfer(1'b0, ADDR_DEGREE, '0, rd);
        if (rd !== APB_DW'(d))
            note_mismatch($sformatf("degree readback exp %0d got %h", d, rd));
        n_degrees++;
    endtask

    // ---------------- tests ----------------

    task automatic test_degree_zero();
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b0, ADDR_DEGREE, '0, rd);
        if (rd !== '0)
            note_mismatch($sformatf("degree after reset exp 0 got %h", rd));
        push_item(mk_req(OP_WRITE, 0, W_MAX, W_MIN, W_MAX, '0));
        push_item(mk_req(OP_EVAL, 5, '0, '0, '0, '0));
        push_item(mk_req(OP_EVAL, 0, '0, '0, '0, W_MIN));
        push_item(mk_req(OP_WRITE, 0, W_MIN, W_MAX, W_MIN, W_MAX));
        push_item(mk_req(OP_EVAL, 31, W_MAX, W_MAX, W_MAX, W_MAX));
    endtask

    task automatic test_degree_one();
        settle();
        set_degree(1);
        push_item(mk_req(OP_WRITE, 0, Q_ONE, Q_ONE / 2, W_MAX, '0));
        push_item(mk_req(OP_WRITE, 1, 2 * Q_ONE, W_MIN, W_MIN, '0));
        push_item(mk_req(OP_EVAL, 0, '0, '0, '0, 3 * Q_ONE));
        push_item(mk_req(OP_EVAL, 0, '0, '0, '0, W_MAX));
        push_item(mk_req(OP_WRITE, 0, Q_ONE, W_MIN, W_MAX, '0));
        push_item(mk_req(OP_EVAL, 0, '0, '0, '0, W_MAX));
        push_item(mk_req(OP_EVAL, 0, '0, '0, '0, W_MIN));
    endtask

    task automatic test_degree_three();
        settle();
        set_degree(3);
        push_item(mk_req(OP_WRITE, 2, -Q_ONE, '0, Q_ONE / 4, '0));
        push_item(mk_req(OP_WRITE, 3, Q_ONE / 2, Q_ONE, W_MAX, '0));
        push_item(mk_req(OP_WRITE, 0, Q_ONE, '0, '0, '0));
        push_item(mk_req(OP_EVAL, 0, '0, '0, '0, '0));
        push_item(mk_req(OP_EVAL, 0, '0, '0, '0, 2 * Q_ONE));
        push_item(mk_req(OP_EVAL, 0, '0, '0, '0, W_MIN));
        push_item(mk_req(OP_EVAL, 0, '0, '0, '0, W_MAX));
    endtask

    // every entry written once so that any degree reads defined data
    task automatic test_table_load();
        req_t r;
        for (int i = 0; i < DEPTH; i++)
        begin
            r       = random_item(0);
            r.index = IDX_W'(i);
            push_item(r);
        end
    endtask

    task automatic run_phase(input int deg, input int count, input int eval_pct);
        settle();
        set_degree(deg);
        repeat (count) push_item(random_item(eval_pct));
    endtask

    task automatic test_random_degrees();
        run_phase(DEPTH - 1, 250, 60);
        run_phase(0, 200, 60);
        run_phase(1, 200, 60);
        run_phase(2, 250, 60);
        run_phase($urandom_range(3, DEPTH - 2), 250, 60);
        run_phase(DEPTH - 1, 200, 60);
        run_phase($urandom_range(0, DEPTH - 1), 150, 60);
    endtask

    task automatic test_backpressure();
        settle();
        set_degree(2);
        hold_req = 1'b1;
        repeat (20) push_item(random_item(100));
    endtask

    task automatic test_quiet_tail();
        settle();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        set_degree($urandom_range(0, DEPTH - 1));
        repeat (300) push_item(random_item(60));
    endtask

    // ---------------- result side ----------------

    initial
    begin
        dout_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                dout_if.ready <= 1'b0;
                repeat (HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 4) == 0)
            begin
                dout_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            else
            begin
                dout_if.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            n_results++;
            seen_res.value = dout_if.value;
            seen_res.d1    = dout_if.first_deriv;
            seen_res.d2    = dout_if.second_deriv;
            seen_res.ovf   = dout_if.overflow;
            if (results_due.size() == 0)
                note_mismatch("result beat with no evaluation pending");
            else
            begin
                due_res  = results_due.pop_front();
                diff_msg = "";
                if (due_res.ovf)
                    n_sat++;
                if (seen_res.value !== due_res.value)
                    diff_msg = {diff_msg, $sformatf(" value exp %h got %h",
                                                    due_res.value, seen_res.value)};
                if (seen_res.d1 !== due_res.d1)
                    diff_msg = {diff_msg, $sformatf(" first_deriv exp %h got %h",
                                                    due_res.d1, seen_res.d1)};
                if (seen_res.d2 !== due_res.d2)
                    diff_msg = {diff_msg, $sformatf(" second_deriv exp %h got %h",
                                                    due_res.d2, seen_res.d2)};
                if (seen_res.ovf !== due_res.ovf)
                    diff_msg = {diff_msg, $sformatf(" overflow exp %b got %b",
                                                    due_res.ovf, seen_res.ovf)};
                if (diff_msg != "")
                    note_mismatch($sformatf("result %0d:%s", n_results, diff_msg));
            end
        end
    end

    // no beat on any port for too long ends the run
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WD_LIMIT)
        begin
            @(posedge clk);
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)
                || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat for %0d cycles", WD_LIMIT);
        $display("tb_orthogonal_poly_eval_with_derivs_core: FAIL");
        $finish;
    end

    // ---------------- sequence ----------------

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        din_if.valid      = 1'b0;
        din_if.op         = OP_WRITE;
        din_if.index      = '0;
        din_if.coef_a     = '0;
        din_if.coef_alpha = '0;
        din_if.coef_beta  = '0;
        din_if.point_x    = '0;
        tx_gaps           = 1'b1;
        rx_gaps           = 1'b1;
        hold_req          = 1'b0;
        deg_shadow        = '0;
        n_err             = 0;
        n_writes          = 0;
        n_evals           = 0;
        n_results         = 0;
        n_sat             = 0;
        n_degrees         = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_degree_zero();
        test_degree_one();
        test_degree_three();
        test_table_load();
        test_random_degrees();
        test_backpressure();
        test_quiet_tail();
        settle();

        if (results_due.size() != 0)
            note_mismatch($sformatf("%0d evaluations never returned", results_due.size()));
        $display("run covered %0d coefficient writes and %0d evaluations over %0d degrees",
                 n_writes, n_evals, n_degrees);
        $display("%0d results checked, %0d with saturation, %0d mismatches",
                 n_results, n_sat, n_err);
        if (n_err == 0)
            $display("tb_orthogonal_poly_eval_with_derivs_core: PASS");
        else
            $display("tb_orthogonal_poly_eval_with_derivs_core: FAIL");
        $finish;
    end

endmodule
